FILE: hdl/rmss_pkg.sv
// shared types and constants for the rgb midpoint stretch and saturation unit
package rmss_pkg;

	localparam int PIX_W   = 8;
	localparam int NUM_W   = 16;
	localparam int DEN_W   = 8;
	localparam int QUO_W   = 8;
	localparam int DIV_LAT = QUO_W + 1;
	localparam int IDX_W   = 2;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
	localparam logic [PIX_W-1:0] MID_VAL = 8'd128;

	localparam logic [PIX_W-1:0] THRESH_BLUE_RST  = 8'd84;
	localparam logic [PIX_W-1:0] THRESH_GREEN_RST = 8'd135;
	localparam logic [PIX_W-1:0] THRESH_RED_RST   = 8'd137;

	localparam logic [IDX_W-1:0] REG_THRESH_BLUE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESH_GREEN = 2'd1;
	localparam logic [IDX_W-1:0] REG_THRESH_RED   = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0] den_t;
	typedef logic [QUO_W-1:0] quo_t;

	typedef struct packed {
		pix_t blue;
		pix_t green;
		pix_t red;
	} pixel_t;

endpackage

FILE: hdl/rmss_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, round half to even
module rmss_div_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  rmss_pkg::num_t num,
	input  rmss_pkg::den_t den,
	output logic          vld_out,
	output rmss_pkg::quo_t quo
);
	import rmss_pkg::*;

	// caller guarantees num < den * 2**QUO_W and den != 0
	logic [QUO_W:0] vld_s;
	num_t           rem_s [0:QUO_W];
	den_t           den_s [0:QUO_W];
	quo_t           quo_s [0:QUO_W];

	logic [DEN_W:0] twice_rem;
	logic [DEN_W:0] den_ext;
	logic           round_up;
	logic           vld_q;
	quo_t           quo_q;

	assign vld_s[0] = vld_in;
	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	genvar k;
	for (k = 0; k < QUO_W; k++) begin : g_step
		localparam int SH = QUO_W - 1 - k;
		logic [NUM_W:0] diff;

		assign diff = {1'b0, rem_s[k]} - ({{(NUM_W + 1 - DEN_W){1'b0}}, den_s[k]} << SH);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= diff[NUM_W] ? rem_s[k] : diff[NUM_W-1:0];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_s[k] | ({{(QUO_W - 1){1'b0}}, ~diff[NUM_W]} << SH);
		end
	end

	// remainder is below den here, so its low bits hold it all
	assign twice_rem = {rem_s[QUO_W][DEN_W-1:0], 1'b0};
	assign den_ext   = {1'b0, den_s[QUO_W]};
	assign round_up  = (twice_rem > den_ext) || ((twice_rem == den_ext) && quo_s[QUO_W][0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		quo_q <= quo_s[QUO_W] + {{(QUO_W - 1){1'b0}}, round_up};
	end

	assign vld_out = vld_q;
	assign quo     = quo_q;

endmodule

FILE: hdl/rmss_lane.sv
// one colour channel: piecewise linear stretch around its threshold
module rmss_lane (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  rmss_pkg::pix_t pix,
	input  rmss_pkg::pix_t thresh,
	output logic          vld_out,
	output rmss_pkg::pix_t result
);
	import rmss_pkg::*;

	logic   upper;
	pix_t   diff;
	num_t   num_c;
	den_t   den_c;

	logic   vld_s1;
	num_t   num_s1;
	den_t   den_s1;
	logic   upper_s [1:DIV_LAT+1];

	logic   div_vld;
	quo_t   div_quo;
	logic [PIX_W:0] sum;

	logic   vld_q;
	pix_t   result_q;

	assign upper = pix > thresh;
	assign diff  = pix - thresh;

	always_comb begin
		if (upper) begin
			num_c = {1'b0, diff, 7'b0};
			den_c = PIX_MAX - thresh;
		end else begin
			num_c = {1'b0, pix, 7'b0};
			den_c = thresh;
		end
		// zero threshold with zero input: numerator is zero, any divisor gives zero
		if (den_c == '0) begin
			den_c = 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		num_s1     <= num_c;
		den_s1     <= den_c;
		upper_s[1] <= upper;
	end

	genvar k;
	for (k = 2; k <= DIV_LAT + 1; k++) begin : g_dly
		always_ff @(posedge clk) begin
			upper_s[k] <= upper_s[k-1];
		end
	end

	rmss_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.num     (num_s1),
		.den     (den_s1),
		.vld_out (div_vld),
		.quo     (div_quo)
	);

	assign sum = {1'b0, div_quo} + {1'b0, MID_VAL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (upper_s[DIV_LAT+1]) begin
			result_q <= sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
		end else begin
			result_q <= div_quo;
		end
	end

	assign vld_out = vld_q;
	assign result  = result_q;

endmodule

FILE: hdl/rmss_merge.sv
// merges the three lanes: max, min and hsv saturation
module rmss_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  rmss_pkg::pixel_t pix,
	output logic            vld_out,
	output rmss_pkg::pixel_t pix_out,
	output rmss_pkg::pix_t   saturation
);
	import rmss_pkg::*;

	pix_t   mx;
	pix_t   mn;
	pix_t   span;
	num_t   num_c;

	logic   vld_s1;
	num_t   num_s1;
	den_t   den_s1;
	pixel_t pix_s [1:DIV_LAT+1];

	logic   div_vld;
	quo_t   div_quo;

	logic   vld_q;
	pixel_t pix_q;
	pix_t   sat_q;

	always_comb begin
		mx = pix.blue;
		mn = pix.blue;
		if (pix.green > mx) begin
			mx = pix.green;
		end
		if (pix.red > mx) begin
			mx = pix.red;
		end
		if (pix.green < mn) begin
			mn = pix.green;
		end
		if (pix.red < mn) begin
			mn = pix.red;
		end
	end

	// span * 255 as a shift and subtract
	assign span  = mx - mn;
	assign num_c = {span, 8'b0} - {8'b0, span};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		num_s1   <= num_c;
		// black pixel: span is zero too, so a divisor of one gives zero
		den_s1   <= (mx == '0) ? 8'd1 : mx;
		pix_s[1] <= pix;
	end

	genvar k;
	for (k = 2; k <= DIV_LAT + 1; k++) begin : g_dly
		always_ff @(posedge clk) begin
			pix_s[k] <= pix_s[k-1];
		end
	end

	rmss_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.num     (num_s1),
		.den     (den_s1),
		.vld_out (div_vld),
		.quo     (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		pix_q <= pix_s[DIV_LAT+1];
		sat_q <= div_quo;
	end

	assign vld_out    = vld_q;
	assign pix_out    = pix_q;
	assign saturation = sat_q;

endmodule

FILE: hdl/rgb_midpoint_stretch_saturation_unit.sv
// top level of the rgb midpoint stretch and saturation unit
//
// Takes one blue, green, red pixel per clock and returns the three channels,
// each stretched piecewise linearly so that its threshold lands on 128, plus
// the hsv saturation of the stretched pixel. An item is taken on every clock
// edge where start is high; busy is always low, so a new pixel may follow
// every cycle, one item per clock sustained. Each result shows up on the out
// ports for exactly one cycle with done high; the receiver cannot stall, so
// it must take every result as it comes. Each item passes through two
// pipelined dividers in series, each working one quotient bit per stage: the
// channel lanes (setup, eight divide steps, rounding, offset and clip) and
// then the merge stage (max and min, eight divide steps, rounding, output
// register). Thresholds are written through wr_en, wr_index and wr_data and
// should only change while no item is in flight; index 3 is ignored.
module rgb_midpoint_stretch_saturation_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  rmss_pkg::pix_t               in_blue,
	input  rmss_pkg::pix_t               in_green,
	input  rmss_pkg::pix_t               in_red,
	// result side
	output logic                         done,
	output rmss_pkg::pix_t               out_blue,
	output rmss_pkg::pix_t               out_green,
	output rmss_pkg::pix_t               out_red,
	output rmss_pkg::pix_t               out_saturation,
	// threshold registers
	input  logic                         wr_en,
	input  logic [rmss_pkg::IDX_W-1:0]   wr_index,
	input  rmss_pkg::pix_t               wr_data
);
	import rmss_pkg::*;

	pix_t   thresh_blue_q;
	pix_t   thresh_green_q;
	pix_t   thresh_red_q;

	logic   take;
	logic   blue_vld;
	logic   green_vld;
	logic   red_vld;
	pixel_t lane_pix;
	pixel_t merged_pix;

	// the pipeline never holds off, so every start is taken
	assign busy = 1'b0;
	assign take = start & ~busy;

	// threshold registers, unknown index falls through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_blue_q  <= THRESH_BLUE_RST;
			thresh_green_q <= THRESH_GREEN_RST;
			thresh_red_q   <= THRESH_RED_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_THRESH_BLUE: begin
					thresh_blue_q <= wr_data;
				end
				REG_THRESH_GREEN: begin
					thresh_green_q <= wr_data;
				end
				REG_THRESH_RED: begin
					thresh_red_q <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// one lane per colour channel, all in lockstep
	rmss_lane u_lane_blue (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (take),
		.pix     (in_blue),
		.thresh  (thresh_blue_q),
		.vld_out (blue_vld),
		.result  (lane_pix.blue)
	);

	rmss_lane u_lane_green (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (take),
		.pix     (in_green),
		.thresh  (thresh_green_q),
		.vld_out (green_vld),
		.result  (lane_pix.green)
	);

	rmss_lane u_lane_red (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (take),
		.pix     (in_red),
		.thresh  (thresh_red_q),
		.vld_out (red_vld),
		.result  (lane_pix.red)
	);

	// saturation from the stretched channels, channels carried alongside
	rmss_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (blue_vld & green_vld & red_vld),
		.pix        (lane_pix),
		.vld_out    (done),
		.pix_out    (merged_pix),
		.saturation (out_saturation)
	);

	assign out_blue  = merged_pix.blue;
	assign out_green = merged_pix.green;
	assign out_red   = merged_pix.red;

endmodule
